>>> sv/pusc_pkg.sv
// Package: sizes, codes and shared types of the peer upload slot choker.
package pusc_pkg;

    localparam int MAX_PEERS = 32;
    localparam int NSLOT     = (MAX_PEERS < 32) ? MAX_PEERS : 32;
    localparam int SLOT_W    = $clog2(NSLOT);
    localparam int CNT_W     = $clog2(NSLOT + 1);
    localparam int RNG_W     = CNT_W - 1;
    localparam int KEY_W     = 36;
    localparam int RND_W     = 16;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_UNCHOKE = 2'd1,
        ACT_CHOKE   = 2'd2
    } t_act;

    typedef enum logic [2:0] {
        C_NOP,
        C_LOAD,
        C_PREP_EL,
        C_PREP_KEY,
        C_TOK_ROT,
        C_TOK_RANK,
        C_SHIFT,
        C_DECIDE
    } t_cell_op;

    typedef enum logic [1:0] {
        REG_SEED       = 2'd0,
        REG_UPLOAD_CAP = 2'd1,
        REG_OPT_IVAL   = 2'd2
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ROT_TOK,
        S_ROT_SHIFT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PREP_EL,
        S_PREP_KEY,
        S_RANK_TOK,
        S_RANK_SHIFT,
        S_DECIDE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        present;
        logic        interested;
        logic        choking;
        logic [31:0] down_rate;
        logic [31:0] up_rate;
        logic [31:0] conn_time;
        logic [31:0] unchoke_time;
    } t_load;

    typedef struct packed {
        t_cell_op    op;
        logic        seed;
        logic [5:0]  regular;
        logic [31:0] now;
    } t_cell_cmd;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic              cand;
        logic              opt;
    } t_tok;

    typedef struct packed {
        logic             present;
        logic             cand;
        t_act             act;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] all;
    } t_cell_stat;

endpackage

>>> sv/peer_upload_slot_choker_top.sv
// Top level: control sequencer, cell ring, remainder unit and result register.
// A run request walks a ring of 32 slot cells: a check step, then an optional
// optimistic rotation (a token load, a ring pass by connection time, a start
// step and the bit-serial remainder, the remainder skipped when no peer
// qualifies), then 2 prep steps, a token load and a ring pass for the rate
// ranking, a decide step, and a scan of the slots out, one result per present
// slot; the scan waits when the result channel stalls. A run on an empty table
// ends after the check step. New requests are taken only idle.
module peer_upload_slot_choker_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot, present, interested, choking, down_rate, up_rate, conn_time,
    // unchoke_time, now_s, random_value
    input  logic [183:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_slot, action, optimistic flag
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int N  = pusc_pkg::NSLOT;
    localparam int SW = pusc_pkg::SLOT_W;
    localparam int CW = pusc_pkg::CNT_W;

    pusc_pkg::t_state     r_state, n_state;
    logic                 r_seed;
    logic [5:0]           r_maxup;
    logic [15:0]          r_ival;
    logic [31:0]          r_now, r_last_rot;
    logic [15:0]          r_rnd;
    logic                 r_opt_valid;
    logic [4:0]           r_opt_slot;
    logic [CW-1:0]        r_step;
    logic [SW-1:0]        r_ptr;
    logic                 r_ovalid, r_olast;
    logic [7:0]           r_odata;

    pusc_pkg::t_cell_cmd  cmd;
    pusc_pkg::t_load      load;
    pusc_pkg::t_tok       tok   [N];
    pusc_pkg::t_cell_stat stat  [N];
    logic [N-1:0]         sel, opt, pres, above;
    logic                 any_present, accept, out_free, div_start, div_done;
    logic [pusc_pkg::RNG_W-1:0] div_range, div_rem;
    logic [CW-1:0]        n_cand;
    logic [4:0]           pick_slot;
    logic [5:0]           regular;
    logic [4:0]           load_slot;

    function automatic logic opt_flag(input logic v, input logic [4:0] s,
                                      input logic [SW-1:0] p);
        return v && (s == 5'(p));
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == pusc_pkg::S_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;
    assign load_slot     = s_axis_tdata[4:0];

    assign load.present      = s_axis_tdata[5];
    assign load.interested   = s_axis_tdata[6];
    assign load.choking      = s_axis_tdata[7];
    assign load.down_rate    = s_axis_tdata[39:8];
    assign load.up_rate      = s_axis_tdata[71:40];
    assign load.conn_time    = s_axis_tdata[103:72];
    assign load.unchoke_time = s_axis_tdata[135:104];

    assign regular = (!r_seed && r_opt_valid) ?
                     ((r_maxup != 6'd0) ? (r_maxup - 6'd1) : 6'd0) : r_maxup;
    assign n_cand  = stat[0].all;

    always_comb begin
        div_range = pusc_pkg::RNG_W'(n_cand >> 2);
        if (div_range == '0) begin
            div_range = pusc_pkg::RNG_W'(1);
        end
    end

    always_comb begin
        pick_slot = 5'd0;
        for (int k = 0; k < N; k++) begin
            sel[k]   = (load_slot == 5'(k));
            opt[k]   = !r_seed && r_opt_valid && (r_opt_slot == 5'(k));
            pres[k]  = stat[k].present;
            above[k] = stat[k].present && (SW'(k) > r_ptr);
            if (stat[k].cand && (stat[k].cnt == CW'(div_rem))) begin
                pick_slot = pick_slot | 5'(k);
            end
        end
    end
    assign any_present = |pres;

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        cmd.op      = pusc_pkg::C_NOP;
        cmd.seed    = r_seed;
        cmd.regular = regular;
        cmd.now     = r_now;
        case (r_state)
            pusc_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser) begin
                        n_state = pusc_pkg::S_CHECK;
                    end else begin
                        cmd.op = pusc_pkg::C_LOAD;
                    end
                end
            end
            pusc_pkg::S_CHECK: begin
                if (!any_present) begin
                    n_state = pusc_pkg::S_IDLE;
                end else if (!r_seed && ((r_now - r_last_rot) >= {16'd0, r_ival})) begin
                    n_state = pusc_pkg::S_ROT_TOK;
                end else begin
                    n_state = pusc_pkg::S_PREP_EL;
                end
            end
            pusc_pkg::S_ROT_TOK: begin
                cmd.op  = pusc_pkg::C_TOK_ROT;
                n_state = pusc_pkg::S_ROT_SHIFT;
            end
            pusc_pkg::S_ROT_SHIFT: begin
                cmd.op = pusc_pkg::C_SHIFT;
                if (r_step == CW'(N - 1)) begin
                    n_state = pusc_pkg::S_DIV_GO;
                end
            end
            pusc_pkg::S_DIV_GO: begin
                if (n_cand == '0) begin
                    n_state = pusc_pkg::S_PREP_EL;
                end else begin
                    div_start = 1'b1;
                    n_state   = pusc_pkg::S_DIV_WAIT;
                end
            end
            pusc_pkg::S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = pusc_pkg::S_PREP_EL;
                end
            end
            pusc_pkg::S_PREP_EL: begin
                cmd.op  = pusc_pkg::C_PREP_EL;
                n_state = pusc_pkg::S_PREP_KEY;
            end
            pusc_pkg::S_PREP_KEY: begin
                cmd.op  = pusc_pkg::C_PREP_KEY;
                n_state = pusc_pkg::S_RANK_TOK;
            end
            pusc_pkg::S_RANK_TOK: begin
                cmd.op  = pusc_pkg::C_TOK_RANK;
                n_state = pusc_pkg::S_RANK_SHIFT;
            end
            pusc_pkg::S_RANK_SHIFT: begin
                cmd.op = pusc_pkg::C_SHIFT;
                if (r_step == CW'(N - 1)) begin
                    n_state = pusc_pkg::S_DECIDE;
                end
            end
            pusc_pkg::S_DECIDE: begin
                cmd.op  = pusc_pkg::C_DECIDE;
                n_state = pusc_pkg::S_EMIT;
            end
            pusc_pkg::S_EMIT: begin
                if ((!pres[r_ptr] || out_free) && (r_ptr == SW'(N - 1))) begin
                    n_state = pusc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pusc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pusc_pkg::S_IDLE;
            r_seed      <= 1'b0;
            r_maxup     <= 6'd4;
            r_ival      <= 16'd30;
            r_last_rot  <= 32'd0;
            r_opt_valid <= 1'b0;
            r_opt_slot  <= 5'd0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    pusc_pkg::REG_SEED:       r_seed  <= i_cfg_wdata[0];
                    pusc_pkg::REG_UPLOAD_CAP: r_maxup <= i_cfg_wdata[5:0];
                    pusc_pkg::REG_OPT_IVAL:   r_ival  <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if ((r_state == pusc_pkg::S_IDLE) && accept && !s_axis_tuser &&
                    !load.present && r_opt_valid && (r_opt_slot == load_slot)) begin
                r_opt_valid <= 1'b0;
                r_opt_slot  <= 5'd0;
            end
            if ((r_state == pusc_pkg::S_CHECK) && (n_state == pusc_pkg::S_ROT_TOK)) begin
                r_last_rot <= r_now;
            end
            if ((r_state == pusc_pkg::S_DIV_GO) && (n_cand == '0)) begin
                r_opt_valid <= 1'b0;
                r_opt_slot  <= 5'd0;
            end
            if ((r_state == pusc_pkg::S_DIV_WAIT) && div_done) begin
                r_opt_valid <= 1'b1;
                r_opt_slot  <= pick_slot;
            end
            if ((r_state == pusc_pkg::S_EMIT) && pres[r_ptr] && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= s_axis_tdata[167:136];
            r_rnd <= s_axis_tdata[183:168];
        end
        if ((r_state == pusc_pkg::S_ROT_TOK) || (r_state == pusc_pkg::S_RANK_TOK)) begin
            r_step <= '0;
        end else begin
            r_step <= r_step + CW'(1);
        end
        if (r_state == pusc_pkg::S_DECIDE) begin
            r_ptr <= '0;
        end else if ((r_state == pusc_pkg::S_EMIT) && (!pres[r_ptr] || out_free)) begin
            r_ptr <= r_ptr + SW'(1);
        end
        if ((r_state == pusc_pkg::S_EMIT) && pres[r_ptr] && out_free) begin
            r_odata <= {opt_flag(r_opt_valid, r_opt_slot, r_ptr), stat[r_ptr].act,
                        5'(r_ptr)};
            r_olast <= ~|above;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        pusc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (SW'(g)),
            .i_cmd   (cmd),
            .i_sel   (sel[g]),
            .i_load  (load),
            .i_opt   (opt[g]),
            .i_tok   (tok[(g + N - 1) % N]),
            .o_tok   (tok[g]),
            .o_stat  (stat[g])
        );
    end

    pusc_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_rnd),
        .i_div   (div_range),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

>>> sv/pusc_cell.sv
// One peer slot cell: slot state, ranking counter and ring token stage.
module pusc_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pusc_pkg::SLOT_W-1:0] i_idx,
    input  pusc_pkg::t_cell_cmd         i_cmd,
    input  logic                        i_sel,
    input  pusc_pkg::t_load             i_load,
    input  logic                        i_opt,
    input  pusc_pkg::t_tok              i_tok,
    output pusc_pkg::t_tok              o_tok,
    output pusc_pkg::t_cell_stat        o_stat
);

    logic                        r_present, r_interested, r_choking, r_cand;
    logic [31:0]                 r_down, r_up, r_conn, r_ut, r_el;
    logic [pusc_pkg::KEY_W-1:0]  r_key;
    logic [pusc_pkg::CNT_W-1:0]  r_cnt, r_all;
    pusc_pkg::t_tok              r_tok;
    pusc_pkg::t_act              r_act;
    logic                        beats;
    logic [pusc_pkg::KEY_W-1:0]  score;

    assign beats = r_tok.cand && ((r_tok.key > r_key) ||
                   ((r_tok.key == r_key) && (r_tok.slot < i_idx)));
    assign score = {4'd0, r_up} + {1'b0, r_el, 3'd0} + {3'd0, r_el, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present    <= 1'b0;
            r_interested <= 1'b0;
            r_choking    <= 1'b0;
        end else begin
            case (i_cmd.op)
                pusc_pkg::C_LOAD: begin
                    if (i_sel) begin
                        r_present    <= i_load.present;
                        r_interested <= i_load.interested;
                        r_choking    <= i_load.choking;
                    end
                end
                pusc_pkg::C_DECIDE: begin
                    if (r_present && r_interested) begin
                        if (i_opt || (r_cnt < i_cmd.regular)) begin
                            r_choking <= 1'b0;
                        end else begin
                            r_choking <= 1'b1;
                        end
                    end else if (r_present && !i_cmd.seed) begin
                        r_choking <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pusc_pkg::C_LOAD: begin
                if (i_sel) begin
                    r_down <= i_load.down_rate;
                    r_up   <= i_load.up_rate;
                    r_conn <= i_load.conn_time;
                    r_ut   <= i_load.unchoke_time;
                end
            end
            pusc_pkg::C_PREP_EL: begin
                r_el  <= (i_cmd.now >= r_ut) ? (i_cmd.now - r_ut) : 32'd0;
                r_act <= pusc_pkg::ACT_NONE;
            end
            pusc_pkg::C_PREP_KEY: begin
                r_key <= i_cmd.seed ? score : {4'd0, r_down};
            end
            pusc_pkg::C_TOK_ROT: begin
                r_key      <= {4'd0, r_conn};
                r_cand     <= r_present && r_interested && r_choking;
                r_tok.key  <= {4'd0, r_conn};
                r_tok.slot <= i_idx;
                r_tok.cand <= r_present && r_interested && r_choking;
                r_tok.opt  <= 1'b0;
                r_cnt      <= '0;
                r_all      <= '0;
            end
            pusc_pkg::C_TOK_RANK: begin
                r_cand     <= r_present && r_interested;
                r_tok.key  <= r_key;
                r_tok.slot <= i_idx;
                r_tok.cand <= r_present && r_interested;
                r_tok.opt  <= i_opt;
                r_cnt      <= '0;
                r_all      <= '0;
            end
            pusc_pkg::C_SHIFT: begin
                if (beats && !r_tok.opt) begin
                    r_cnt <= r_cnt + pusc_pkg::CNT_W'(1);
                end
                if (r_tok.cand) begin
                    r_all <= r_all + pusc_pkg::CNT_W'(1);
                end
                r_tok <= i_tok;
            end
            pusc_pkg::C_DECIDE: begin
                if (r_present && r_interested) begin
                    if (i_opt || (r_cnt < i_cmd.regular)) begin
                        if (r_choking) begin
                            r_act <= pusc_pkg::ACT_UNCHOKE;
                            r_ut  <= i_cmd.now;
                        end
                    end else if (!r_choking) begin
                        r_act <= pusc_pkg::ACT_CHOKE;
                    end
                end else if (r_present && !i_cmd.seed && !r_choking) begin
                    r_act <= pusc_pkg::ACT_CHOKE;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tok          = r_tok;
    assign o_stat.present = r_present;
    assign o_stat.cand    = r_cand;
    assign o_stat.act     = r_act;
    assign o_stat.cnt     = r_cnt;
    assign o_stat.all     = r_all;

endmodule

>>> sv/pusc_mod.sv
// Bit-serial remainder unit: random value modulo the optimistic pick range.
module pusc_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pusc_pkg::RND_W-1:0] i_num,
    input  logic [pusc_pkg::RNG_W-1:0] i_div,
    output logic                       o_done,
    output logic [pusc_pkg::RNG_W-1:0] o_rem
);

    logic                       r_busy, r_done;
    logic [3:0]                 r_step;
    logic [pusc_pkg::RND_W-1:0] r_q;
    logic [pusc_pkg::RNG_W-1:0] r_rem, r_div;
    logic [pusc_pkg::RNG_W:0]   trial;

    assign trial = {r_rem, r_q[pusc_pkg::RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == 4'd15)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num;
            r_div  <= i_div;
            r_rem  <= '0;
            r_step <= 4'd0;
        end else if (r_busy) begin
            r_q    <= {r_q[pusc_pkg::RND_W-2:0], 1'b0};
            r_step <= r_step + 4'd1;
            if (trial >= {1'b0, r_div}) begin
                r_rem <= pusc_pkg::RNG_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[pusc_pkg::RNG_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
